### design/clr_pkg.sv
// Shared constants, codes and types of the clipped line rasteriser.
`default_nettype none
package clr_pkg;

   localparam int COORD_BITS    = 16;
   localparam int MAX_FRAME_DIM = 1024;
   localparam int DIM_BITS      = 11;
   localparam int PIX_BITS      = $clog2(MAX_FRAME_DIM);
   localparam int ADDR_BITS     = 2 * PIX_BITS;
   localparam int COLOR_BITS    = 16;
   localparam int CLIP_BITS     = COORD_BITS + 24;
   localparam int DELTA_BITS    = COORD_BITS + 2;
   localparam int PROD_BITS     = CLIP_BITS + DELTA_BITS;
   localparam int CNT_BITS      = $clog2(PROD_BITS + 1);
   localparam int ERR_BITS      = PIX_BITS + 3;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } md_state_type;

   typedef enum logic [2:0] {
      SU_IDLE,
      SU_MIN_CHK,
      SU_MIN_WAIT,
      SU_MAJ_CHK,
      SU_MAJ_WAIT,
      SU_NEXT,
      SU_FIN
   } su_state_type;

   typedef struct packed {
      logic                         start;
      logic signed [CLIP_BITS-1:0]  a;
      logic signed [DELTA_BITS-1:0] b;
      logic signed [DELTA_BITS-1:0] c;
   } md_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [CLIP_BITS-1:0] q;
   } md_rsp_type;

   typedef struct packed {
      logic                       steep;
      logic [PIX_BITS-1:0]        major_pos;
      logic [PIX_BITS-1:0]        major_end;
      logic [PIX_BITS-1:0]        minor_pos;
      logic                       minor_dir;
      logic signed [ERR_BITS-1:0] error_term;
      logic signed [ERR_BITS-1:0] error_inc_keep;
      logic signed [ERR_BITS-1:0] error_inc_move;
   } line_setup_type;

endpackage
`default_nettype wire

### design/clr_muldiv.sv
// Iterative signed a*b/c unit: shift-add multiply then restoring divide.
`default_nettype none
module clr_muldiv import clr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire md_req_type md_req,
   output md_rsp_type      md_rsp
);

   md_state_type           state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]   acc_ff, acc_in;
   logic [PROD_BITS-1:0]   mcand_ff, mcand_in;
   logic [DELTA_BITS-1:0]  mplier_ff, mplier_in;
   logic [DELTA_BITS-1:0]  div_ff, div_in;
   logic [DELTA_BITS-1:0]  rem_ff, rem_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;
   logic [DELTA_BITS:0]    rem_sh;
   logic [DELTA_BITS:0]    rem_diff;
   logic [CLIP_BITS-1:0]   a_mag;
   logic [DELTA_BITS-1:0]  b_mag;
   logic [DELTA_BITS-1:0]  c_mag;
   logic [CLIP_BITS-1:0]   q_mag;

   always_comb begin
      a_mag = md_req.a[CLIP_BITS-1]  ? -md_req.a : md_req.a;
      b_mag = md_req.b[DELTA_BITS-1] ? -md_req.b : md_req.b;
      c_mag = md_req.c[DELTA_BITS-1] ? -md_req.c : md_req.c;
      rem_sh   = {rem_ff, acc_ff[PROD_BITS-1]};
      rem_diff = rem_sh - {1'b0, div_ff};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE: if (md_req.start) state_in = MD_MUL;
         MD_MUL:  if (cnt_ff == CNT_BITS'(DELTA_BITS - 1)) state_in = MD_DIV;
         MD_DIV:  if (cnt_ff == CNT_BITS'(PROD_BITS - 1)) state_in = MD_DONE;
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   // Datapath.
   always_comb begin
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      unique case (state_ff)
         MD_IDLE: begin
            cnt_in    = '0;
            acc_in    = '0;
            rem_in    = '0;
            mcand_in  = PROD_BITS'(a_mag);
            mplier_in = b_mag;
            div_in    = c_mag;
            neg_in    = (md_req.a[CLIP_BITS-1] ^ md_req.b[DELTA_BITS-1])
                        ^ md_req.c[DELTA_BITS-1];
            zero_in   = (md_req.c == '0);
         end
         MD_MUL: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = (cnt_ff == CNT_BITS'(DELTA_BITS - 1)) ? '0 : cnt_ff + 1'b1;
         end
         MD_DIV: begin
            if (!rem_diff[DELTA_BITS]) begin
               rem_in = rem_diff[DELTA_BITS-1:0];
               acc_in = {acc_ff[PROD_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DELTA_BITS-1:0];
               acc_in = {acc_ff[PROD_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         MD_DONE: cnt_in = '0;
         default: cnt_in = '0;
      endcase
   end

   // Outputs.
   always_comb begin
      q_mag       = acc_ff[CLIP_BITS-1:0];
      md_rsp.done = (state_ff == MD_DONE);
      if (zero_ff)     md_rsp.q = '0;
      else if (neg_ff) md_rsp.q = -q_mag;
      else             md_rsp.q = q_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
   end

endmodule
`default_nettype wire

### design/clr_setup.sv
// Sequencer that clips both endpoints and derives the Bresenham set-up.
`default_nettype none
module clr_setup import clr_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [COORD_BITS-1:0] start_x,
   input  wire logic signed [COORD_BITS-1:0] start_y,
   input  wire logic signed [COORD_BITS-1:0] end_x,
   input  wire logic signed [COORD_BITS-1:0] end_y,
   input  wire logic [DIM_BITS-1:0]          lim_w,
   input  wire logic [DIM_BITS-1:0]          lim_h,
   output logic                              busy,
   output logic                              done,
   output line_setup_type                    setup,
   output md_req_type                        md_req,
   input  wire md_rsp_type                   md_rsp
);

   su_state_type                 state_ff, state_in;
   logic                         pt_ff, pt_in;
   logic signed [CLIP_BITS-1:0]  cur_maj_ff, cur_maj_in, cur_mnr_ff, cur_mnr_in;
   logic signed [CLIP_BITS-1:0]  oth_maj_ff, oth_maj_in, oth_mnr_ff, oth_mnr_in;
   logic signed [DELTA_BITS-1:0] dmaj_ff, dmaj_in, dmin_ff, dmin_in;
   logic [DIM_BITS-1:0]          lmaj_ff, lmaj_in, lmin_ff, lmin_in;
   logic                         steep_ff, steep_in;

   logic signed [DELTA_BITS-1:0] dx, dy;
   logic [DELTA_BITS-1:0]        dx_mag, dy_mag;
   logic                         steep_now;
   logic signed [CLIP_BITS-1:0]  maj_hi, mnr_hi, maj_clamp, mnr_clamp;
   logic                         maj_out, mnr_out;
   logic [PIX_BITS-1:0]          p1_maj, p1_mnr, p2_maj, p2_mnr, amaj, amin;
   logic signed [ERR_BITS-1:0]   keep2, maj2;

   always_comb begin
      dx        = DELTA_BITS'(start_x) - DELTA_BITS'(end_x);
      dy        = DELTA_BITS'(start_y) - DELTA_BITS'(end_y);
      dx_mag    = dx[DELTA_BITS-1] ? -dx : dx;
      dy_mag    = dy[DELTA_BITS-1] ? -dy : dy;
      steep_now = dy_mag > dx_mag;

      maj_hi    = CLIP_BITS'(lmaj_ff - 1'b1);
      mnr_hi    = CLIP_BITS'(lmin_ff - 1'b1);
      maj_out   = cur_maj_ff[CLIP_BITS-1] || (cur_maj_ff > maj_hi);
      mnr_out   = cur_mnr_ff[CLIP_BITS-1] || (cur_mnr_ff > mnr_hi);
      maj_clamp = cur_maj_ff[CLIP_BITS-1] ? '0 : ((cur_maj_ff > maj_hi) ? maj_hi : cur_maj_ff);
      mnr_clamp = cur_mnr_ff[CLIP_BITS-1] ? '0 : ((cur_mnr_ff > mnr_hi) ? mnr_hi : cur_mnr_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SU_IDLE:     if (start) state_in = SU_MIN_CHK;
         SU_MIN_CHK:  state_in = mnr_out ? SU_MIN_WAIT : SU_MAJ_CHK;
         SU_MIN_WAIT: if (md_rsp.done) state_in = SU_MAJ_CHK;
         SU_MAJ_CHK:  state_in = maj_out ? SU_MAJ_WAIT : SU_NEXT;
         SU_MAJ_WAIT: if (md_rsp.done) state_in = SU_NEXT;
         SU_NEXT:     state_in = pt_ff ? SU_FIN : SU_MIN_CHK;
         SU_FIN:      state_in = SU_IDLE;
         default:     state_in = SU_IDLE;
      endcase
   end

   // Datapath.
   always_comb begin
      pt_in      = pt_ff;
      cur_maj_in = cur_maj_ff;
      cur_mnr_in = cur_mnr_ff;
      oth_maj_in = oth_maj_ff;
      oth_mnr_in = oth_mnr_ff;
      dmaj_in    = dmaj_ff;
      dmin_in    = dmin_ff;
      lmaj_in    = lmaj_ff;
      lmin_in    = lmin_ff;
      steep_in   = steep_ff;
      unique case (state_ff)
         SU_IDLE: begin
            pt_in    = 1'b0;
            steep_in = steep_now;
            if (steep_now) begin
               cur_maj_in = CLIP_BITS'(start_y);
               cur_mnr_in = CLIP_BITS'(start_x);
               oth_maj_in = CLIP_BITS'(end_y);
               oth_mnr_in = CLIP_BITS'(end_x);
               dmaj_in    = dy;
               dmin_in    = dx;
               lmaj_in    = lim_h;
               lmin_in    = lim_w;
            end else begin
               cur_maj_in = CLIP_BITS'(start_x);
               cur_mnr_in = CLIP_BITS'(start_y);
               oth_maj_in = CLIP_BITS'(end_x);
               oth_mnr_in = CLIP_BITS'(end_y);
               dmaj_in    = dx;
               dmin_in    = dy;
               lmaj_in    = lim_w;
               lmin_in    = lim_h;
            end
         end
         SU_MIN_WAIT: if (md_rsp.done) begin
            cur_maj_in = cur_maj_ff + md_rsp.q;
            cur_mnr_in = mnr_clamp;
         end
         SU_MAJ_WAIT: if (md_rsp.done) begin
            cur_mnr_in = cur_mnr_ff + md_rsp.q;
            cur_maj_in = maj_clamp;
         end
         SU_NEXT: begin
            if (pt_ff) begin
               cur_mnr_in = mnr_clamp;
            end else begin
               // First endpoint is finished: park it and clip the second.
               pt_in      = 1'b1;
               cur_maj_in = oth_maj_ff;
               cur_mnr_in = oth_mnr_ff;
               oth_maj_in = cur_maj_ff;
               oth_mnr_in = mnr_clamp;
            end
         end
         default: pt_in = pt_ff;
      endcase
   end

   // Outputs.
   always_comb begin
      busy       = (state_ff != SU_IDLE);
      done       = (state_ff == SU_FIN);
      md_req     = '0;
      md_req.start = ((state_ff == SU_MIN_CHK) && mnr_out)
                  || ((state_ff == SU_MAJ_CHK) && maj_out);
      if (state_ff == SU_MIN_CHK) begin
         md_req.a = mnr_clamp - cur_mnr_ff;
         md_req.b = dmaj_ff;
         md_req.c = dmin_ff;
      end else begin
         md_req.a = maj_clamp - cur_maj_ff;
         md_req.b = dmin_ff;
         md_req.c = dmaj_ff;
      end

      p1_maj = oth_maj_ff[PIX_BITS-1:0];
      p1_mnr = oth_mnr_ff[PIX_BITS-1:0];
      p2_maj = cur_maj_ff[PIX_BITS-1:0];
      p2_mnr = cur_mnr_ff[PIX_BITS-1:0];
      amaj   = (p1_maj > p2_maj) ? p1_maj - p2_maj : p2_maj - p1_maj;
      amin   = (p1_mnr > p2_mnr) ? p1_mnr - p2_mnr : p2_mnr - p1_mnr;
      keep2  = ERR_BITS'({amin, 1'b0});
      maj2   = ERR_BITS'({amaj, 1'b0});

      setup.steep          = steep_ff;
      setup.error_inc_keep = keep2;
      setup.error_inc_move = keep2 - maj2;
      setup.error_term     = keep2 - ERR_BITS'(amaj);
      // Equal major coordinates start from the end point.
      if (p1_maj < p2_maj) begin
         setup.major_pos = p1_maj;
         setup.minor_pos = p1_mnr;
         setup.major_end = p2_maj;
         setup.minor_dir = p2_mnr < p1_mnr;
      end else begin
         setup.major_pos = p2_maj;
         setup.minor_pos = p2_mnr;
         setup.major_end = p1_maj;
         setup.minor_dir = p1_mnr < p2_mnr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SU_IDLE;
         pt_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pt_ff    <= pt_in;
      end
      cur_maj_ff <= cur_maj_in;
      cur_mnr_ff <= cur_mnr_in;
      oth_maj_ff <= oth_maj_in;
      oth_mnr_ff <= oth_mnr_in;
      dmaj_ff    <= dmaj_in;
      dmin_ff    <= dmin_in;
      lmaj_ff    <= lmaj_in;
      lmin_ff    <= lmin_in;
      steep_ff   <= steep_in;
   end

endmodule
`default_nettype wire

### design/clipped_line_rasterizer.sv
// Top level of the clipped line rasteriser: registers, line walker, result stage.
//
//   channel | direction | handshake          | carries
//   req_    | in        | req_valid/req_stall | operation, endpoints, colour
//   rsp_    | out       | rsp_valid/rsp_stall | pixel x, y, address, colour, last flag
//   csr_    | in        | csr_valid/csr_ready | register index, write data
//
// A step item, with a line active, yields one pixel a cycle while the result is not stalled.
// A start item keeps the block busy while both endpoints are clipped: up to four
// a*b/c evaluations on the one shared unit, each after its check state (18 multiply
// steps, 58 divide steps and one hand-over state).
// Reset is synchronous and active high; it clears the line and all control state.
// A waiting result is held in the output register; a new item is taken while it
// waits only if it is being taken in the same cycle.
`default_nettype none
module clipped_line_rasterizer import clr_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_operation,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   input  wire logic [COLOR_BITS-1:0]        req_draw_color,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [PIX_BITS-1:0]               rsp_pixel_x,
   output logic [PIX_BITS-1:0]               rsp_pixel_y,
   output logic [ADDR_BITS-1:0]              rsp_pixel_address,
   output logic [COLOR_BITS-1:0]             rsp_pixel_value,
   output logic                              rsp_last_pixel,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [DIM_BITS-1:0]          csr_data
);

   // Configuration registers keep the written bits; the effective size is
   // saturated into one to the maximum frame dimension.
   logic [DIM_BITS-1:0]  width_ff, width_in, height_ff, height_in;
   logic [DIM_BITS-1:0]  eff_w, eff_h;

   // Walker state.
   logic                       line_active_ff, line_active_in;
   logic                       steep_ff, steep_in;
   logic [PIX_BITS-1:0]        major_pos_ff, major_pos_in;
   logic [PIX_BITS-1:0]        major_end_ff, major_end_in;
   logic [PIX_BITS-1:0]        minor_pos_ff, minor_pos_in;
   logic                       minor_dir_ff, minor_dir_in;
   logic signed [ERR_BITS-1:0] error_ff, error_in;
   logic signed [ERR_BITS-1:0] inc_keep_ff, inc_keep_in;
   logic signed [ERR_BITS-1:0] inc_move_ff, inc_move_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0]   px_ff, px_in, py_ff, py_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic                  last_ff, last_in;
   logic [COLOR_BITS-1:0] value_ff, value_in;

   logic                  req_fire, start_fire, step_fire, is_last;
   logic [PIX_BITS-1:0]   px, py;
   logic                  setup_busy, setup_done;
   line_setup_type        setup;
   md_req_type            md_req;
   md_rsp_type            md_rsp;

   clr_setup u_setup (
      .clock   (clock),
      .reset   (reset),
      .start   (start_fire),
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .lim_w   (eff_w),
      .lim_h   (eff_h),
      .busy    (setup_busy),
      .done    (setup_done),
      .setup   (setup),
      .md_req  (md_req),
      .md_rsp  (md_rsp)
   );

   clr_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_comb begin
      eff_w = (width_ff == '0) ? DIM_BITS'(1)
            : ((width_ff > DIM_BITS'(MAX_FRAME_DIM)) ? DIM_BITS'(MAX_FRAME_DIM) : width_ff);
      eff_h = (height_ff == '0) ? DIM_BITS'(1)
            : ((height_ff > DIM_BITS'(MAX_FRAME_DIM)) ? DIM_BITS'(MAX_FRAME_DIM) : height_ff);

      csr_ready  = 1'b1;
      req_stall  = setup_busy || (rsp_valid_ff && rsp_stall);
      req_fire   = req_valid && !req_stall;
      start_fire = req_fire && (req_operation == OP_START);
      step_fire  = req_fire && (req_operation == OP_STEP) && line_active_ff;

      px      = steep_ff ? minor_pos_ff : major_pos_ff;
      py      = steep_ff ? major_pos_ff : minor_pos_ff;
      is_last = major_pos_ff >= major_end_ff;
   end

   // Configuration writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            default:          width_in  = width_ff;
         endcase
      end
   end

   // Line walker: the pixel is emitted before the error term moves on.
   always_comb begin
      line_active_in = line_active_ff;
      steep_in       = steep_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      minor_dir_in   = minor_dir_ff;
      error_in       = error_ff;
      inc_keep_in    = inc_keep_ff;
      inc_move_in    = inc_move_ff;
      color_in       = color_ff;
      if (start_fire) color_in = req_draw_color;
      if (setup_done) begin
         line_active_in = 1'b1;
         steep_in       = setup.steep;
         major_pos_in   = setup.major_pos;
         major_end_in   = setup.major_end;
         minor_pos_in   = setup.minor_pos;
         minor_dir_in   = setup.minor_dir;
         error_in       = setup.error_term;
         inc_keep_in    = setup.error_inc_keep;
         inc_move_in    = setup.error_inc_move;
      end else if (step_fire) begin
         if (error_ff[ERR_BITS-1]) begin
            error_in = error_ff + inc_keep_ff;
         end else begin
            minor_pos_in = minor_dir_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
            error_in     = error_ff + inc_move_ff;
         end
         major_pos_in = major_pos_ff + 1'b1;
         if (is_last) line_active_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      addr_in      = addr_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (step_fire) begin
         rsp_valid_in = 1'b1;
         px_in        = px;
         py_in        = py;
         addr_in      = ADDR_BITS'(py) * ADDR_BITS'(eff_w) + ADDR_BITS'(px);
         value_in     = color_ff;
         last_in      = is_last;
      end
   end

   always_comb begin
      rsp_valid         = rsp_valid_ff;
      rsp_pixel_x       = px_ff;
      rsp_pixel_y       = py_ff;
      rsp_pixel_address = addr_ff;
      rsp_pixel_value   = value_ff;
      rsp_last_pixel    = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= DIM_BITS'(256);
         height_ff      <= DIM_BITS'(192);
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         steep_ff       <= 1'b0;
         major_pos_ff   <= '0;
         major_end_ff   <= '0;
         minor_pos_ff   <= '0;
         minor_dir_ff   <= 1'b0;
         error_ff       <= '0;
         inc_keep_ff    <= '0;
         inc_move_ff    <= '0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         steep_ff       <= steep_in;
         major_pos_ff   <= major_pos_in;
         major_end_ff   <= major_end_in;
         minor_pos_ff   <= minor_pos_in;
         minor_dir_ff   <= minor_dir_in;
         error_ff       <= error_in;
         inc_keep_ff    <= inc_keep_in;
         inc_move_ff    <= inc_move_in;
      end
      color_ff <= color_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      addr_ff  <= addr_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

`ifndef SYNTHESIS
   // A finished set-up always leaves an active line behind it.
   a_setup_arms_line: assert property (@(posedge clock) disable iff (reset)
      setup_done |=> line_active_ff)
      else $error("line not active after set-up");

   // The walker never runs past the far end of an active line.
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> (major_pos_ff <= major_end_ff))
      else $error("major position beyond line end");

   // A new pixel only appears when a line was active.
   a_pixel_needs_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(line_active_ff))
      else $error("pixel emitted without an active line");
`endif

endmodule
`default_nettype wire
